/* src/sdhs_pkg.sv */
// Types, codes and helpers shared by the stall-detect homing sequencer.
package sdhs_pkg;

  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned JOINT_W    = 3;
  localparam int unsigned TQ_W       = 16;
  localparam int unsigned VEL_W      = 16;
  localparam int unsigned LEVEL_W    = 15;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned DIR_W      = 16;
  localparam int unsigned OUT_DATA_W = 32;

  // Register indexes (byte address is four times the index).
  localparam logic [2:0] REG_TORQUE_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_DWELL_TICKS      = 3'd1;
  localparam logic [2:0] REG_TIMEOUT_TICKS    = 3'd2;
  localparam logic [2:0] REG_HOMING_SPEED     = 3'd3;
  localparam logic [2:0] REG_DIRECTION_CODES  = 3'd4;

  // Function codes carried in tuser.
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_ABORT = 2'd2;

  // Direction codes.
  localparam logic [1:0] DIR_SKIP = 2'b00;
  localparam logic [1:0] DIR_POS  = 2'b01;

  // Offset selection codes.
  localparam logic [2:0] OFS_NONE       = 3'd0;
  localparam logic [2:0] OFS_HIP_UPPER  = 3'd1;
  localparam logic [2:0] OFS_HIP_LOWER  = 3'd2;
  localparam logic [2:0] OFS_KNEE_UPPER = 3'd3;
  localparam logic [2:0] OFS_KNEE_LOWER = 3'd4;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DRIVE = 2'd1,
    PH_DWELL = 2'd2,
    PH_DONE  = 2'd3
  } phase_e;

  typedef struct packed {
    logic [LEVEL_W-1:0] torque_threshold;
    logic [TICK_W-1:0]  dwell_ticks;
    logic [TICK_W-1:0]  timeout_ticks;
    logic [LEVEL_W-1:0] homing_speed;
    logic [DIR_W-1:0]   direction_codes;
  } cfg_t;

  typedef struct packed {
    logic [JOINT_W-1:0] joint;
    logic [VEL_W-1:0]   velocity_cmd;
    logic               busy_res;
    logic [2:0]         offset_select;
    logic               joint_done;
    logic               joint_ok;
    logic               all_done;
    logic               all_ok;
    logic               aborted;
  } result_t;

  function automatic logic [1:0] dir_code(input logic [DIR_W-1:0] codes,
                                          input logic [JOINT_W-1:0] j);
    return codes[{j, 1'b0} +: 2];
  endfunction

endpackage

/* src/sdhs_regs.sv */
// Configuration register file with its APB-style access port.
module sdhs_regs
  import sdhs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_TORQUE_THRESHOLD: cfg_d.torque_threshold = pwdata[LEVEL_W-1:0];
        REG_DWELL_TICKS:      cfg_d.dwell_ticks      = pwdata[TICK_W-1:0];
        REG_TIMEOUT_TICKS:    cfg_d.timeout_ticks    = pwdata[TICK_W-1:0];
        REG_HOMING_SPEED:     cfg_d.homing_speed     = pwdata[LEVEL_W-1:0];
        REG_DIRECTION_CODES:  cfg_d.direction_codes  = pwdata[DIR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_TORQUE_THRESHOLD: prdata[LEVEL_W-1:0] = cfg_q.torque_threshold;
      REG_DWELL_TICKS:      prdata[TICK_W-1:0]  = cfg_q.dwell_ticks;
      REG_TIMEOUT_TICKS:    prdata[TICK_W-1:0]  = cfg_q.timeout_ticks;
      REG_HOMING_SPEED:     prdata[LEVEL_W-1:0] = cfg_q.homing_speed;
      REG_DIRECTION_CODES:  prdata[DIR_W-1:0]   = cfg_q.direction_codes;
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* src/stall_detect_homing_sequencer_unit.sv */
// A result word is registered and valid in the cycle after its input word is accepted.
// Throughput: one word per cycle; the step logic updates the sequencer state
// and the result register at the same edge, and input is taken whenever the
// result register is empty or being drained.
// Reset: asynchronous, active low; state goes idle, flags and registers to zero.
module stall_detect_homing_sequencer_unit
  import sdhs_pkg::*;
#(
  parameter int unsigned NUM_JOINTS = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // APB-style configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // input words
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [TQ_W-1:0]       s_axis_tdata,  // [15:0] torque
  input  logic [1:0]            s_axis_tuser,  // [1:0] func
  // result words
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [2:0] joint, [18:3] velocity_cmd, [19] busy_res, [22:20] offset_select,
  // [23] joint_done, [24] joint_ok, [25] all_done, [26] all_ok, [27] aborted,
  // [31:28] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  cfg_t cfg;

  sdhs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  phase_e                 phase_q, phase_d;
  logic [JOINT_W-1:0]     cur_q, cur_d;
  logic [TICK_W-1:0]      elapsed_q, elapsed_d;
  logic [TICK_W-1:0]      dwell_q, dwell_d;
  logic [NUM_JOINTS-1:0]  succ_q, succ_d;
  logic                   abort_q, abort_d;
  logic                   out_valid_q;
  result_t                res_q, res_d;

  logic                   accept;
  logic [1:0]             func;
  logic signed [TQ_W-1:0] tq;
  logic [TQ_W-1:0]        mag;
  logic                   at_stop;
  logic                   busy_now, busy_next;
  logic                   fin, good;
  logic [1:0]             code;
  logic [3:0]             nj;
  logic                   all_good;

  // First requested joint at or above 'from', NUM_JOINTS when there is none.
  function automatic logic [3:0] next_joint(input logic [3:0] from,
                                            input logic [DIR_W-1:0] codes);
    logic [3:0] r;
    logic       hit;
    r   = 4'(NUM_JOINTS);
    hit = 1'b0;
    for (int j = 0; j < 8; j++) begin
      if (!hit && (j < NUM_JOINTS) && (4'(j) >= from) &&
          (dir_code(codes, 3'(j)) != DIR_SKIP)) begin
        r   = 4'(j);
        hit = 1'b1;
      end
    end
    return r;
  endfunction

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign func          = s_axis_tuser;
  assign tq            = s_axis_tdata;
  // Negating the most negative torque wraps to 0x8000, which is its magnitude.
  assign mag           = tq[TQ_W-1] ? (~s_axis_tdata + 16'd1) : s_axis_tdata;
  assign at_stop       = mag >= {1'b0, cfg.torque_threshold};
  assign busy_now      = (phase_q == PH_DRIVE) || (phase_q == PH_DWELL);

  always_comb begin
    phase_d   = phase_q;
    cur_d     = cur_q;
    elapsed_d = elapsed_q;
    dwell_d   = dwell_q;
    succ_d    = succ_q;
    abort_d   = abort_q;
    fin       = 1'b0;
    good      = 1'b0;
    nj        = '0;
    res_d     = '0;

    if (func == FUNC_START && !busy_now) begin
      succ_d  = '0;
      abort_d = 1'b0;
      cur_d   = '0;
      nj      = next_joint(4'd0, cfg.direction_codes);
      if (nj < 4'(NUM_JOINTS)) begin
        phase_d   = PH_DRIVE;
        cur_d     = nj[JOINT_W-1:0];
        elapsed_d = '0;
        dwell_d   = '0;
      end else begin
        phase_d = PH_DONE;
      end
    end else if (func == FUNC_ABORT && busy_now) begin
      abort_d = 1'b1;
      phase_d = PH_DONE;
    end else if (func == FUNC_TICK && busy_now) begin
      if (phase_q == PH_DRIVE) begin
        if (elapsed_q >= cfg.timeout_ticks) begin
          fin = 1'b1;
        end else begin
          if (elapsed_q != '1) elapsed_d = elapsed_q + 16'd1;
          if (at_stop) begin
            if (cfg.dwell_ticks == '0) begin
              fin  = 1'b1;
              good = 1'b1;
            end else begin
              phase_d = PH_DWELL;
              dwell_d = '0;
            end
          end
        end
      end else begin
        if (elapsed_q != '1) elapsed_d = elapsed_q + 16'd1;
        if (!at_stop) begin
          phase_d = PH_DRIVE;
        end else begin
          if (dwell_q != '1) dwell_d = dwell_q + 16'd1;
          if (dwell_d >= cfg.dwell_ticks) begin
            fin  = 1'b1;
            good = 1'b1;
          end
        end
      end

      if (fin) begin
        res_d.joint_done = 1'b1;
        res_d.joint_ok   = good;
        if (good) begin
          for (int i = 0; i < NUM_JOINTS; i++) begin
            if (cur_q == JOINT_W'(i)) succ_d[i] = 1'b1;
          end
          if (cur_q <= 3'd1) begin
            res_d.offset_select = (dir_code(cfg.direction_codes, cur_q) == DIR_POS) ?
                                  OFS_HIP_UPPER : OFS_HIP_LOWER;
          end else if (cur_q <= 3'd3) begin
            res_d.offset_select = (dir_code(cfg.direction_codes, cur_q) == DIR_POS) ?
                                  OFS_KNEE_UPPER : OFS_KNEE_LOWER;
          end else begin
            res_d.offset_select = OFS_NONE;
          end
        end
        nj = next_joint({1'b0, cur_q} + 4'd1, cfg.direction_codes);
        if (nj < 4'(NUM_JOINTS)) begin
          phase_d   = PH_DRIVE;
          cur_d     = nj[JOINT_W-1:0];
          elapsed_d = '0;
          dwell_d   = '0;
        end else begin
          phase_d = PH_DONE;
        end
      end
    end

    busy_next = (phase_d == PH_DRIVE) || (phase_d == PH_DWELL);

    // No abort, and every requested joint must have its success flag, judged on live codes.
    all_good = !abort_d;
    for (int i = 0; i < NUM_JOINTS; i++) begin
      if ((dir_code(cfg.direction_codes, JOINT_W'(i)) != DIR_SKIP) && !succ_d[i]) begin
        all_good = 1'b0;
      end
    end

    code = dir_code(cfg.direction_codes, cur_d);
    res_d.joint    = cur_d;
    res_d.busy_res = busy_next;
    if (!fin && busy_next) begin
      if (code[1]) begin
        res_d.velocity_cmd = -{1'b0, cfg.homing_speed};
      end else if (code == DIR_POS) begin
        res_d.velocity_cmd = {1'b0, cfg.homing_speed};
      end
    end
    res_d.all_done = (phase_d == PH_DONE);
    res_d.all_ok   = (phase_d == PH_DONE) && all_good;
    res_d.aborted  = abort_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cur_q       <= '0;
      elapsed_q   <= '0;
      dwell_q     <= '0;
      succ_q      <= '0;
      abort_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q     <= phase_d;
        cur_q       <= cur_d;
        elapsed_q   <= elapsed_d;
        dwell_q     <= dwell_d;
        succ_q      <= succ_d;
        abort_q     <= abort_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (accept) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, res_q.aborted, res_q.all_ok, res_q.all_done,
                          res_q.joint_ok, res_q.joint_done, res_q.offset_select,
                          res_q.busy_res, res_q.velocity_cmd, res_q.joint};

`ifndef ASSERT_OFF
  // A joint being homed is always one that exists.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q == PH_DRIVE) || (phase_q == PH_DWELL)) |-> ({1'b0, cur_q} < 4'(NUM_JOINTS)))
    else $error("homing joint index out of range");

  // The finishing word of a joint never carries a velocity command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.joint_done) |-> (res_q.velocity_cmd == '0))
    else $error("velocity commanded on joint completion");

  // A chosen offset only comes with a successful joint.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.offset_select != OFS_NONE)) |-> (res_q.joint_done && res_q.joint_ok))
    else $error("offset selected without success");

  // A start taken while not busy always leaves the idle phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (func == FUNC_START) && !busy_now) |=> (phase_q != PH_IDLE))
    else $error("start did not leave idle");

  // Busy and sequence end never show together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.busy_res && res_q.all_done))
    else $error("busy and all_done both set");
`endif

endmodule
